### rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition in one cycle implies a condition in the same cycle.
`define ASSERT_SAME(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("checker assertion failed");

// Check that a condition in one cycle implies a condition in the next cycle.
`define ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("checker assertion failed");

`endif

### rtl/core/hsv2rgb_pkg.sv
// Types, constants and tables shared by the HSV to RGB converter modules.
`default_nettype none

package hsv2rgb_pkg;

	// Fixed-point format of saturation, value and the sector fraction
	localparam int FRAC_BITS = 12;
	localparam int UNIT_W    = FRAC_BITS + 1;
	localparam int ONE       = 1 << FRAC_BITS;
	localparam int PROD_W    = 2 * UNIT_W;

	// Stream payload widths
	localparam int IN_FIELD_W = 16;
	localparam int IN_DATA_W  = 3 * IN_FIELD_W;
	localparam int CHAN_W     = 8;
	localparam int OUT_DATA_W = 3 * CHAN_W;

	// Hue reduction: the biased hue is hue + 32768 + 352, and 32768 + 352 is
	// a multiple of 360, so its remainder mod 360 equals the wrapped hue.
	localparam int BIAS_W      = IN_FIELD_W + 1;
	localparam int HUE_BIAS    = 352;
	localparam int DEG_FULL    = 360;
	localparam int DEG_SECTOR  = 60;
	localparam int NUM_SECTORS = 6;
	// floor(2^20 / 360); the quotient estimate is exact or one low
	localparam int RECIP       = 2912;
	localparam int RECIP_W     = 12;
	localparam int RECIP_SHIFT = 20;
	localparam int QUO_W       = 9;
	localparam int QPROD_W     = BIAS_W + RECIP_W;
	localparam int REM_W       = 10;
	localparam int HUE_MOD_W   = 9;
	localparam int WITHIN_W    = 6;
	localparam int FRAC_TABLE_DEPTH = 1 << WITHIN_W;
	localparam int BYTE_SCALE  = 255;
	localparam int SCALED_W    = UNIT_W + CHAN_W;

	typedef logic [UNIT_W-1:0]    unit_t;
	typedef logic [FRAC_BITS-1:0] frac_t;
	typedef frac_t frac_table_t [FRAC_TABLE_DEPTH];

	// 60-degree sector of the color wheel
	typedef enum logic [2:0] {
		SEC_R_TO_Y = 3'd0,
		SEC_Y_TO_G = 3'd1,
		SEC_G_TO_C = 3'd2,
		SEC_C_TO_B = 3'd3,
		SEC_B_TO_M = 3'd4,
		SEC_M_TO_R = 3'd5
	} sector_t;

	// Sector and fraction with clamped saturation and value
	typedef struct packed {
		sector_t sector;
		frac_t   frac;
		unit_t   sat;
		unit_t   val;
	} hue_item_t;

	// Sector with the four candidate channel levels
	typedef struct packed {
		sector_t sector;
		unit_t   val;
		unit_t   p;
		unit_t   q;
		unit_t   t;
	} level_item_t;

	// Fraction within a sector: floor((within << FRAC_BITS) / 60)
	function automatic frac_table_t build_frac_table();
		frac_table_t tbl;
		for (int i = 0; i < FRAC_TABLE_DEPTH; i++) begin
			tbl[i] = (i < DEG_SECTOR) ? frac_t'((i << FRAC_BITS) / DEG_SECTOR) : '0;
		end
		return tbl;
	endfunction

	localparam frac_table_t FRAC_TABLE = build_frac_table();

endpackage

`default_nettype wire

### rtl/core/hsv2rgb_sector.sv
// Stages 1-3: clamp saturation and value, wrap the hue, find sector and fraction.
`default_nettype none

module hsv2rgb_sector
	import hsv2rgb_pkg::*;
(
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output      logic                         in_ready,
	input  wire logic signed [IN_FIELD_W-1:0] hue_degrees,
	input  wire logic signed [IN_FIELD_W-1:0] saturation,
	input  wire logic signed [IN_FIELD_W-1:0] brightness,
	output      logic                         out_valid,
	input  wire logic                         out_ready,
	output      hue_item_t                    out_item
);

	function automatic unit_t clamp_unit(logic signed [IN_FIELD_W-1:0] x);
		if (x < 0) begin
			return '0;
		end
		if (int'(x) > ONE) begin
			return unit_t'(ONE);
		end
		return unit_t'(x);
	endfunction

	logic                   vld_s1, vld_s2, vld_s3;
	logic                   rdy_s1, rdy_s2, rdy_s3;
	logic [BIAS_W-1:0]      bias_s1;
	logic [QUO_W-1:0]       quo_s1;
	unit_t                  sat_s1, val_s1, sat_s2, val_s2;
	logic [HUE_MOD_W-1:0]   hue_s2;
	hue_item_t              item_s3;

	logic [BIAS_W-1:0]      hue_bias;
	logic [QPROD_W-1:0]     quo_prod;
	logic [BIAS_W-1:0]      quo_times_full;
	logic [BIAS_W-1:0]      rem_full;
	logic [REM_W-1:0]       rem_low;
	logic [REM_W-1:0]       hue_mod;
	logic [2:0]             sect_cnt;
	logic [HUE_MOD_W-1:0]   sector_base;
	logic [WITHIN_W-1:0]    sect_offset;

	// Handshake: a stage loads when it is empty or its successor loads
	assign rdy_s3   = !vld_s3 || out_ready;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
		end
	end

	// Stage 1: bias the hue to unsigned and estimate the quotient by 360
	assign hue_bias = BIAS_W'({~hue_degrees[IN_FIELD_W-1], hue_degrees[IN_FIELD_W-2:0]})
		+ BIAS_W'(HUE_BIAS);
	assign quo_prod = QPROD_W'(hue_bias) * QPROD_W'(RECIP);

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			bias_s1 <= hue_bias;
			quo_s1  <= quo_prod[RECIP_SHIFT +: QUO_W];
			sat_s1  <= clamp_unit(saturation);
			val_s1  <= clamp_unit(brightness);
		end
	end

	// Stage 2: remainder with one correction step gives the hue in 0..359
	assign quo_times_full = BIAS_W'(quo_s1) * BIAS_W'(DEG_FULL);
	assign rem_full       = bias_s1 - quo_times_full;
	assign rem_low        = rem_full[REM_W-1:0];
	assign hue_mod        = (rem_low >= REM_W'(DEG_FULL)) ? rem_low - REM_W'(DEG_FULL) : rem_low;

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			hue_s2 <= hue_mod[HUE_MOD_W-1:0];
			sat_s2 <= sat_s1;
			val_s2 <= val_s1;
		end
	end

	// Stage 3: sector by threshold compares, fraction from the table
	always_comb begin
		sect_cnt = '0;
		for (int k = 1; k < NUM_SECTORS; k++) begin
			if (hue_s2 >= HUE_MOD_W'(k * DEG_SECTOR)) sect_cnt = sect_cnt + 3'd1;
		end
	end

	assign sector_base = HUE_MOD_W'(sect_cnt) * HUE_MOD_W'(DEG_SECTOR);
	assign sect_offset = WITHIN_W'(hue_s2 - sector_base);

	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s2) begin
			item_s3.sector <= sector_t'(sect_cnt);
			item_s3.frac   <= FRAC_TABLE[sect_offset];
			item_s3.sat    <= sat_s2;
			item_s3.val    <= val_s2;
		end
	end

	assign out_valid = vld_s3;
	assign out_item  = item_s3;

endmodule

`default_nettype wire

### rtl/core/hsv2rgb_blend.sv
// Stages 4-5: form the channel levels p, q and t from value, saturation and fraction.
`default_nettype none

module hsv2rgb_blend
	import hsv2rgb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire hue_item_t   in_item,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      level_item_t out_item
);

	logic        vld_s4, vld_s5;
	logic        rdy_s4, rdy_s5;
	sector_t     sector_s4;
	unit_t       val_s4, p_s4, sf_s4, sfc_s4;
	level_item_t item_s5;

	unit_t              one_minus_frac, one_minus_sat, one_minus_sf, one_minus_sfc;
	logic [PROD_W-1:0]  sf_prod, sfc_prod, p_prod, q_prod, t_prod;

	// Handshake: a stage loads when it is empty or its successor loads
	assign rdy_s5   = !vld_s5 || out_ready;
	assign rdy_s4   = !vld_s4 || rdy_s5;
	assign in_ready = rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy_s4) vld_s4 <= in_valid;
			if (rdy_s5) vld_s5 <= vld_s4;
		end
	end

	// Stage 4: s*f, s*(1-f) and p = v*(1-s), each truncated
	assign one_minus_frac = unit_t'(ONE) - unit_t'(in_item.frac);
	assign one_minus_sat  = unit_t'(ONE) - in_item.sat;
	assign sf_prod        = PROD_W'(in_item.sat) * PROD_W'(in_item.frac);
	assign sfc_prod       = PROD_W'(in_item.sat) * PROD_W'(one_minus_frac);
	assign p_prod         = PROD_W'(in_item.val) * PROD_W'(one_minus_sat);

	always_ff @(posedge clk) begin
		if (rdy_s4 && in_valid) begin
			sector_s4 <= in_item.sector;
			val_s4    <= in_item.val;
			sf_s4     <= sf_prod[FRAC_BITS +: UNIT_W];
			sfc_s4    <= sfc_prod[FRAC_BITS +: UNIT_W];
			p_s4      <= p_prod[FRAC_BITS +: UNIT_W];
		end
	end

	// Stage 5: q = v*(1-s*f) and t = v*(1-s*(1-f))
	assign one_minus_sf  = unit_t'(ONE) - sf_s4;
	assign one_minus_sfc = unit_t'(ONE) - sfc_s4;
	assign q_prod        = PROD_W'(val_s4) * PROD_W'(one_minus_sf);
	assign t_prod        = PROD_W'(val_s4) * PROD_W'(one_minus_sfc);

	always_ff @(posedge clk) begin
		if (rdy_s5 && vld_s4) begin
			item_s5.sector <= sector_s4;
			item_s5.val    <= val_s4;
			item_s5.p      <= p_s4;
			item_s5.q      <= q_prod[FRAC_BITS +: UNIT_W];
			item_s5.t      <= t_prod[FRAC_BITS +: UNIT_W];
		end
	end

	assign out_valid = vld_s5;
	assign out_item  = item_s5;

endmodule

`default_nettype wire

### rtl/core/hsv2rgb_channel.sv
// Stage 6: permute levels onto red, green and blue and scale each to a byte.
`default_nettype none

module hsv2rgb_channel
	import hsv2rgb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output      logic              in_ready,
	input  wire level_item_t       in_item,
	output      logic              out_valid,
	input  wire logic              out_ready,
	output      logic [CHAN_W-1:0] red,
	output      logic [CHAN_W-1:0] green,
	output      logic [CHAN_W-1:0] blue
);

	function automatic logic [CHAN_W-1:0] to_byte(unit_t c);
		logic [SCALED_W-1:0] scaled;
		scaled = SCALED_W'(c) * SCALED_W'(BYTE_SCALE);
		return scaled[FRAC_BITS +: CHAN_W];
	endfunction

	logic              vld_s6;
	logic              rdy_s6;
	logic [CHAN_W-1:0] red_s6, green_s6, blue_s6;
	unit_t             r_lvl, g_lvl, b_lvl;

	// Hold the result while the sink stalls
	assign rdy_s6   = !vld_s6 || out_ready;
	assign in_ready = rdy_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (rdy_s6) begin
			vld_s6 <= in_valid;
		end
	end

	// Select the channel permutation of the sector
	always_comb begin
		case (in_item.sector)
			SEC_Y_TO_G: begin
				r_lvl = in_item.q; g_lvl = in_item.val; b_lvl = in_item.p;
			end
			SEC_G_TO_C: begin
				r_lvl = in_item.p; g_lvl = in_item.val; b_lvl = in_item.t;
			end
			SEC_C_TO_B: begin
				r_lvl = in_item.p; g_lvl = in_item.q; b_lvl = in_item.val;
			end
			SEC_B_TO_M: begin
				r_lvl = in_item.t; g_lvl = in_item.p; b_lvl = in_item.val;
			end
			SEC_M_TO_R: begin
				r_lvl = in_item.val; g_lvl = in_item.p; b_lvl = in_item.q;
			end
			default: begin
				r_lvl = in_item.val; g_lvl = in_item.t; b_lvl = in_item.p;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy_s6 && in_valid) begin
			red_s6   <= to_byte(r_lvl);
			green_s6 <= to_byte(g_lvl);
			blue_s6  <= to_byte(b_lvl);
		end
	end

	assign out_valid = vld_s6;
	assign red       = red_s6;
	assign green     = green_s6;
	assign blue      = blue_s6;

endmodule

`default_nettype wire

### rtl/core/hsv_to_rgb_converter.sv
// HSV to RGB converter top level: stream ports around a six-stage pipeline.
//
// Converts HSV (signed hue in whole degrees, saturation and value in signed Q3.12,
// clamped to 0..1) to an 8-bit RGB triple. Every transaction passes through six
// register stages; the throughput is one pixel per clock while the sink is ready,
// set by the fully pipelined datapath (hue reduction, sector lookup, two multiplier
// stages and the channel scaling stage). Each stage holds its own valid bit, so a
// stall on the output fills the empty stages before s_axis_tready drops. The block
// keeps no state between pixels.
`default_nettype none

module hsv_to_rgb_converter
	import hsv2rgb_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output      logic                  s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // hue_degrees, saturation, brightness
	output      logic                  m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output      logic [OUT_DATA_W-1:0] m_axis_tdata   // red, green, blue
);

	logic        hue_valid, hue_ready;
	hue_item_t   hue_item;
	logic        lvl_valid, lvl_ready;
	level_item_t lvl_item;
	logic [CHAN_W-1:0] red, green, blue;

	// Hue wrap, clamping, sector and fraction
	hsv2rgb_sector u_sector (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.hue_degrees (s_axis_tdata[0 +: IN_FIELD_W]),
		.saturation  (s_axis_tdata[IN_FIELD_W +: IN_FIELD_W]),
		.brightness  (s_axis_tdata[2*IN_FIELD_W +: IN_FIELD_W]),
		.out_valid   (hue_valid),
		.out_ready   (hue_ready),
		.out_item    (hue_item)
	);

	// Channel levels p, q and t
	hsv2rgb_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (hue_valid),
		.in_ready  (hue_ready),
		.in_item   (hue_item),
		.out_valid (lvl_valid),
		.out_ready (lvl_ready),
		.out_item  (lvl_item)
	);

	// Permutation, byte scaling and output register
	hsv2rgb_channel u_channel (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (lvl_valid),
		.in_ready  (lvl_ready),
		.in_item   (lvl_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

	assign m_axis_tdata = {blue, green, red};

endmodule

`default_nettype wire

### rtl/core/hsv2rgb_checker.sv
// Port-level checker for the HSV to RGB converter, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module hsv2rgb_checker
	import hsv2rgb_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_axis_tvalid,
	input wire logic                  s_axis_tready,
	input wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	input wire logic                  m_axis_tvalid,
	input wire logic                  m_axis_tready,
	input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

	logic in_xfer;

	assign in_xfer = s_axis_tvalid && s_axis_tready;

	// Hold a stalled result unchanged
	`ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// Deliver an accepted transaction on the output when the sink never stalls and reset stays released
	`ASSERT_NEXT(a_latency, $past(in_xfer, 5) && $past(m_axis_tready, 4) && $past(m_axis_tready, 3) && $past(m_axis_tready, 2) && $past(m_axis_tready, 1) && m_axis_tready && $past(arst_n, 5) && $past(arst_n, 4) && $past(arst_n, 3) && $past(arst_n, 2) && $past(arst_n, 1), m_axis_tvalid)

	// Start empty after reset
	`ASSERT_SAME(a_reset_empty, $past(!arst_n), !m_axis_tvalid)

	// Accept input whenever the output stage is empty
	`ASSERT_SAME(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_checker (.*);

`default_nettype wire
